@@ src/sixaic_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sixaic_pkg: shared types and arithmetic for the six-axis input conditioner
// Register map, event codes, sequencer states, and fixed-point helpers.
// ----------------------------------------------------------------------------
package sixaic_pkg;

  localparam int NUM_BUTTONS  = 32;
  localparam int BUTTON_LIMIT = (NUM_BUTTONS < 32) ? NUM_BUTTONS : 32;
  localparam int NUM_AXES     = 6;
  localparam int PADDR_W      = 5;

  typedef logic signed [15:0] raw_t;
  typedef logic signed [15:0] norm_t;
  typedef logic signed [23:0] out_axis_t;
  typedef logic signed [40:0] prod_t;
  typedef logic signed [24:0] coef_t;
  typedef logic [16:0]        idle_cnt_t;

  localparam raw_t      RAW_MIN  = 16'sh8000;
  localparam raw_t      RAW_MAX  = 16'sh7FFF;
  localparam idle_cnt_t IDLE_MAX = 17'h1FFFF;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_MOTION  = 2'd1,
    OP_BUTTON  = 2'd2,
    OP_UNKNOWN = 2'd3
  } op_t;

  typedef enum logic {
    KIND_TWIST = 1'b0,
    KIND_JOY   = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    REG_INV_FULL_SCALE   = 3'd0,
    REG_LINEAR_GAIN      = 3'd1,
    REG_ANGULAR_GAIN     = 3'd2,
    REG_STATIC_THRESHOLD = 3'd3,
    REG_STATIC_ZERO_ALL  = 3'd4,
    REG_TRANS_DEADBAND   = 3'd5,
    REG_ROT_DEADBAND     = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_NORM,
    S_DECIDE,
    S_TWIST,
    S_JOY
  } state_t;

  typedef struct packed {
    logic [23:0]        inv_full_scale;
    logic signed [15:0] linear_gain;
    logic signed [15:0] angular_gain;
    logic [15:0]        static_threshold;
    logic               static_zero_all;
    logic [14:0]        trans_deadband;
    logic [14:0]        rot_deadband;
  } cfg_t;

  localparam logic [23:0] RST_INV_FULL_SCALE   = 24'd32768;
  localparam logic [15:0] RST_LINEAR_GAIN      = 16'd256;
  localparam logic [15:0] RST_ANGULAR_GAIN     = 16'd256;
  localparam logic [15:0] RST_STATIC_THRESHOLD = 16'd30;
  localparam logic        RST_STATIC_ZERO_ALL  = 1'b1;
  localparam logic [14:0] RST_TRANS_DEADBAND   = 15'd1638;
  localparam logic [14:0] RST_ROT_DEADBAND     = 15'd1638;

  typedef struct packed {
    logic [1:0] operation;
    raw_t       raw_x;
    raw_t       raw_y;
    raw_t       raw_z;
    raw_t       raw_rx;
    raw_t       raw_ry;
    raw_t       raw_rz;
    logic [7:0] button_index;
    logic       button_pressed;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic        last_of_run;
    out_axis_t   lin_x;
    out_axis_t   lin_y;
    out_axis_t   lin_z;
    out_axis_t   ang_x;
    out_axis_t   ang_y;
    out_axis_t   ang_z;
    logic [31:0] button_bits;
    logic [5:0]  buttons_known;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic apply_event;
    logic mul_norm;
    logic write_norm;
    logic mul_twist;
    logic load_twist;
    logic load_joy;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic motion_pending;
    logic joy_pending;
    logic out_free;
  } sts_t;

  function automatic raw_t neg_sat(raw_t r);
    raw_t n;
    n = -r;
    return (r == RAW_MIN) ? RAW_MAX : n;
  endfunction

  // Q.24 product to Q2.14: round half up, floor shift, clamp to 16 bits
  function automatic norm_t norm_round(prod_t p);
    prod_t s;
    s = (p + 41'sd512) >>> 10;
    if (s > 41'sd32767) return 16'sh7FFF;
    else if (s < -41'sd32768) return 16'sh8000;
    else return s[15:0];
  endfunction

  // Q2.14 times Q8.8 to Q10.14, clamp to 24 bits
  function automatic out_axis_t twist_round(prod_t p);
    prod_t s;
    s = (p + 41'sd128) >>> 8;
    if (s > 41'sd8388607) return 24'sh7FFFFF;
    else if (s < -41'sd8388608) return 24'sh800000;
    else return s[23:0];
  endfunction

endpackage
`default_nettype wire

@@ src/sixaic_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sixaic_if: request channels of the six-axis input conditioner
// Device event channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sixaic_item_if;
  import sixaic_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] operation;
  raw_t       raw_x;
  raw_t       raw_y;
  raw_t       raw_z;
  raw_t       raw_rx;
  raw_t       raw_ry;
  raw_t       raw_rz;
  logic [7:0] button_index;
  logic       button_pressed;

  modport source (
    output valid, operation, raw_x, raw_y, raw_z, raw_rx, raw_ry, raw_rz,
           button_index, button_pressed,
    input  ready
  );
  modport sink (
    input  valid, operation, raw_x, raw_y, raw_z, raw_rx, raw_ry, raw_rz,
           button_index, button_pressed,
    output ready
  );
endinterface

interface sixaic_result_if;
  import sixaic_pkg::*;

  logic        valid;
  logic        ready;
  logic        result_kind;
  logic        last_of_run;
  out_axis_t   lin_x;
  out_axis_t   lin_y;
  out_axis_t   lin_z;
  out_axis_t   ang_x;
  out_axis_t   ang_y;
  out_axis_t   ang_z;
  logic [31:0] button_bits;
  logic [5:0]  buttons_known;

  modport source (
    output valid, result_kind, last_of_run, lin_x, lin_y, lin_z, ang_x, ang_y,
           ang_z, button_bits, buttons_known,
    input  ready
  );
  modport sink (
    input  valid, result_kind, last_of_run, lin_x, lin_y, lin_z, ang_x, ang_y,
           ang_z, button_bits, buttons_known,
    output ready
  );
endinterface
`default_nettype wire

@@ src/sixaic_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sixaic_regs: configuration register file
// APB-style write and read of the seven conditioner settings.
// ----------------------------------------------------------------------------
module sixaic_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sixaic_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output sixaic_pkg::cfg_t                  cfg
);
  import sixaic_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_full_scale   <= RST_INV_FULL_SCALE;
      cfg.linear_gain      <= RST_LINEAR_GAIN;
      cfg.angular_gain     <= RST_ANGULAR_GAIN;
      cfg.static_threshold <= RST_STATIC_THRESHOLD;
      cfg.static_zero_all  <= RST_STATIC_ZERO_ALL;
      cfg.trans_deadband   <= RST_TRANS_DEADBAND;
      cfg.rot_deadband     <= RST_ROT_DEADBAND;
    end else if (wr) begin
      case (idx)
        REG_INV_FULL_SCALE:   cfg.inv_full_scale   <= pwdata[23:0];
        REG_LINEAR_GAIN:      cfg.linear_gain      <= pwdata[15:0];
        REG_ANGULAR_GAIN:     cfg.angular_gain     <= pwdata[15:0];
        REG_STATIC_THRESHOLD: cfg.static_threshold <= pwdata[15:0];
        REG_STATIC_ZERO_ALL:  cfg.static_zero_all  <= pwdata[0];
        REG_TRANS_DEADBAND:   cfg.trans_deadband   <= pwdata[14:0];
        REG_ROT_DEADBAND:     cfg.rot_deadband     <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_INV_FULL_SCALE:   prdata = {8'd0, cfg.inv_full_scale};
      REG_LINEAR_GAIN:      prdata = {16'd0, cfg.linear_gain};
      REG_ANGULAR_GAIN:     prdata = {16'd0, cfg.angular_gain};
      REG_STATIC_THRESHOLD: prdata = {16'd0, cfg.static_threshold};
      REG_STATIC_ZERO_ALL:  prdata = {31'd0, cfg.static_zero_all};
      REG_TRANS_DEADBAND:   prdata = {17'd0, cfg.trans_deadband};
      REG_ROT_DEADBAND:     prdata = {17'd0, cfg.rot_deadband};
      default:              prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

@@ src/sixaic_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sixaic_ctrl: event sequencer
// Steps one event through update, normalize, and up to two result loads.
// ----------------------------------------------------------------------------
module sixaic_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sixaic_pkg::sts_t  sts,
  output sixaic_pkg::cmd_t       cmd
);
  import sixaic_pkg::*;

  state_t state, state_next;
  logic   twist_go;

  assign twist_go = sts.motion_pending & ((sts.op == OP_TICK) | sts.joy_pending);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_LOAD;
      S_LOAD:   state_next = (sts.op == OP_MOTION) ? S_NORM : S_DECIDE;
      S_NORM:   state_next = S_DECIDE;
      S_DECIDE: begin
        if (twist_go) state_next = S_TWIST;
        else if (sts.joy_pending) state_next = S_JOY;
        else state_next = S_IDLE;
      end
      S_TWIST:  if (sts.out_free) state_next = S_JOY;
      S_JOY:    if (sts.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_LOAD: begin
        cmd.apply_event = 1'b1;
        cmd.mul_norm    = (sts.op == OP_MOTION);
      end
      S_NORM:   cmd.write_norm = 1'b1;
      S_DECIDE: cmd.mul_twist  = twist_go;
      S_TWIST:  cmd.load_twist = sts.out_free;
      S_JOY:    cmd.load_joy   = sts.out_free;
      default: ;
    endcase
  end

  a_twist_then_joy: assert property (@(posedge clk) disable iff (rst)
    cmd.load_twist |=> state == S_JOY)
    else $error("twist result not followed by joy result");

endmodule
`default_nettype wire

@@ src/sixaic_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sixaic_dp: conditioner datapath
// Six multiplier lanes, axis state, idle counter, buttons, result register.
// ----------------------------------------------------------------------------
module sixaic_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sixaic_pkg::cfg_t  cfg,
  input  wire sixaic_pkg::cmd_t  cmd,
  output sixaic_pkg::sts_t       sts,
  input  wire sixaic_pkg::item_t item_in,
  input  wire logic              result_ready,
  output logic                   result_valid,
  output sixaic_pkg::res_t       result
);
  import sixaic_pkg::*;

  item_t       itm;
  op_t         op;
  norm_t       normed [NUM_AXES];
  prod_t       prod   [NUM_AXES];
  raw_t        mul_a  [NUM_AXES];
  coef_t       mul_b  [NUM_AXES];
  raw_t        src    [NUM_AXES];
  logic [16:0] mag    [NUM_AXES];
  logic        in_band[NUM_AXES];
  idle_cnt_t   idle_count;
  idle_cnt_t   cnt_inc;
  logic        motion_pending;
  logic        joy_pending;
  logic [31:0] button_state;
  logic [5:0]  button_extent;
  logic [5:0]  extent_new;
  logic        button_ok;
  logic        zero_trans;
  logic        zero_rot;
  logic        out_valid;
  kind_t       out_kind;
  logic        out_last;
  out_axis_t   out_axes[NUM_AXES];
  logic [31:0] out_bits;
  logic [5:0]  out_known;
  coef_t       lin_coef;
  coef_t       ang_coef;
  coef_t       inv_coef;

  assign op = op_t'(itm.operation);

  always_ff @(posedge clk) begin
    if (cmd.latch) itm <= item_in;
  end

  // remap device axes to vx vy vz wx wy wz
  assign src[0] = itm.raw_z;
  assign src[1] = neg_sat(itm.raw_x);
  assign src[2] = itm.raw_y;
  assign src[3] = itm.raw_rz;
  assign src[4] = neg_sat(itm.raw_rx);
  assign src[5] = itm.raw_ry;

  assign inv_coef = $signed({1'b0, cfg.inv_full_scale});
  assign lin_coef = {{9{cfg.linear_gain[15]}}, cfg.linear_gain};
  assign ang_coef = {{9{cfg.angular_gain[15]}}, cfg.angular_gain};

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      mul_a[i] = cmd.mul_twist ? normed[i] : src[i];
      if (cmd.mul_twist) mul_b[i] = (i < 3) ? lin_coef : ang_coef;
      else mul_b[i] = inv_coef;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (cmd.mul_norm || cmd.mul_twist) prod[i] <= mul_a[i] * mul_b[i];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      mag[i]     = normed[i][15] ? (17'd0 - {1'b1, normed[i]}) : {1'b0, normed[i]};
      in_band[i] = mag[i] < ((i < 3) ? {2'b0, cfg.trans_deadband}
                                     : {2'b0, cfg.rot_deadband});
    end
  end

  assign zero_trans = cfg.static_zero_all | (in_band[0] & in_band[1] & in_band[2]);
  assign zero_rot   = cfg.static_zero_all | (in_band[3] & in_band[4] & in_band[5]);
  assign cnt_inc    = (idle_count == IDLE_MAX) ? idle_count : idle_count + 17'd1;
  assign button_ok  = itm.button_index < 8'(BUTTON_LIMIT);
  assign extent_new = {1'b0, itm.button_index[4:0]} + 6'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) normed[i] <= '0;
      idle_count     <= '0;
      motion_pending <= 1'b0;
      joy_pending    <= 1'b0;
      button_state   <= '0;
      button_extent  <= '0;
    end else begin
      if (cmd.apply_event && op == OP_TICK) begin
        if (cnt_inc > {1'b0, cfg.static_threshold}) begin
          for (int i = 0; i < NUM_AXES; i++) begin
            if ((i < 3) ? zero_trans : zero_rot) normed[i] <= '0;
          end
          idle_count     <= '0;
          motion_pending <= 1'b1;
        end else begin
          idle_count <= cnt_inc;
        end
      end
      if (cmd.apply_event && op == OP_BUTTON && button_ok) begin
        button_state[itm.button_index[4:0]] <= itm.button_pressed;
        if (button_extent < extent_new) button_extent <= extent_new;
        joy_pending <= 1'b1;
      end
      if (cmd.write_norm) begin
        for (int i = 0; i < NUM_AXES; i++) normed[i] <= norm_round(prod[i]);
        motion_pending <= 1'b1;
      end
      if (cmd.load_twist) begin
        idle_count     <= '0;
        motion_pending <= 1'b0;
        joy_pending    <= 1'b1;
      end
    end
  end

  // result register: refill as soon as the held request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_twist || cmd.load_joy) begin
      out_valid <= 1'b1;
    end else if (result_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_twist) begin
      out_kind  <= KIND_TWIST;
      out_last  <= 1'b0;
      out_bits  <= '0;
      out_known <= '0;
      for (int i = 0; i < NUM_AXES; i++) out_axes[i] <= twist_round(prod[i]);
    end else if (cmd.load_joy) begin
      out_kind  <= KIND_JOY;
      out_last  <= 1'b1;
      out_bits  <= button_state;
      out_known <= button_extent;
      for (int i = 0; i < NUM_AXES; i++) out_axes[i] <= {{8{normed[i][15]}}, normed[i]};
    end
  end

  assign sts.op             = op;
  assign sts.motion_pending = motion_pending;
  assign sts.joy_pending    = joy_pending;
  assign sts.out_free       = ~out_valid | result_ready;

  assign result_valid         = out_valid;
  assign result.result_kind   = out_kind;
  assign result.last_of_run   = out_last;
  assign result.lin_x         = out_axes[0];
  assign result.lin_y         = out_axes[1];
  assign result.lin_z         = out_axes[2];
  assign result.ang_x         = out_axes[3];
  assign result.ang_y         = out_axes[4];
  assign result.ang_z         = out_axes[5];
  assign result.button_bits   = out_bits;
  assign result.buttons_known = out_known;

  a_twist_clears_motion: assert property (@(posedge clk) disable iff (rst)
    cmd.load_twist |=> joy_pending && !motion_pending && idle_count == '0)
    else $error("twist emission did not update pending state");

  a_joy_needs_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.load_joy |-> joy_pending)
    else $error("joy result loaded without joy pending");

  a_twist_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_TWIST) |-> (out_bits == '0 && out_known == '0 && !out_last))
    else $error("twist result carries joy fields");

  a_norm_only_motion: assert property (@(posedge clk) disable iff (rst)
    cmd.write_norm |-> op == OP_MOTION)
    else $error("axes normalized for a non-motion event");

endmodule
`default_nettype wire

@@ src/six_axis_input_conditioner.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// six_axis_input_conditioner: motion, button and idle-tick event conditioner
// Normalizes six-axis samples, applies static zeroing, emits twist and joy.
// ----------------------------------------------------------------------------
// Sequence: an accepted event is latched and applied, normalized if it is
//   motion, then at most a twist result followed by a joy result is loaded
//   into the single result register, each waiting while it is held. A new
//   event is accepted only once the sequencer is back in idle.
// Reset: synchronous; axes, counter, buttons and pending flags clear and
//   the registers return to their defaults. No clearing pass.
module six_axis_input_conditioner (
  input  wire logic                             clk,
  input  wire logic                             rst,
  sixaic_item_if.sink                           item,
  sixaic_result_if.source                       result,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [sixaic_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import sixaic_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  sts_t  sts;
  item_t item_in;
  res_t  res;
  logic  in_ready;
  logic  res_valid;

  assign item_in.operation      = item.operation;
  assign item_in.raw_x          = item.raw_x;
  assign item_in.raw_y          = item.raw_y;
  assign item_in.raw_z          = item.raw_z;
  assign item_in.raw_rx         = item.raw_rx;
  assign item_in.raw_ry         = item.raw_ry;
  assign item_in.raw_rz         = item.raw_rz;
  assign item_in.button_index   = item.button_index;
  assign item_in.button_pressed = item.button_pressed;
  assign item.ready             = in_ready;

  sixaic_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sixaic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sixaic_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .item_in      (item_in),
    .result_ready (result.ready),
    .result_valid (res_valid),
    .result       (res)
  );

  assign result.valid         = res_valid;
  assign result.result_kind   = res.result_kind;
  assign result.last_of_run   = res.last_of_run;
  assign result.lin_x         = res.lin_x;
  assign result.lin_y         = res.lin_y;
  assign result.lin_z         = res.lin_z;
  assign result.ang_x         = res.ang_x;
  assign result.ang_y         = res.ang_y;
  assign result.ang_z         = res.ang_z;
  assign result.button_bits   = res.button_bits;
  assign result.buttons_known = res.buttons_known;

endmodule
`default_nettype wire
